// ----- rtl/ket_pkg.sv -----
package ket_pkg;

  // Table geometry
  localparam int CAPACITY  = 16;
  localparam int ID_BITS   = 16;
  localparam int TIME_BITS = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Port field widths
  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;

  // Action codes
  localparam logic ACT_SCHEDULE = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORTENED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;

  typedef struct packed {
    logic              action;
    logic [ID_W-1:0]   object_id;
    logic [TIME_W-1:0] lifetime;
    logic [TIME_W-1:0] elapsed;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     expired_id;
    logic                last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_REMOVE,
    S_PLACE,
    S_SUB,
    S_POP
  } state_t;

endpackage

// ----- rtl/keyed_expiry_timer_table_top.sv -----
// Schedule steps from request to result: key search, shift-out of the old entry, shift-in
//   from the back, one slot per cycle through one unit.
// Tick steps: saturating subtract over every entry, then one result per expired entry, or a
//   single none result if none expired; done pulses once per result, the receiver cannot stall.
// Throughput: one request at a time; busy drops in the cycle that shows the last result.
// Reset: rst (synchronous) empties the table and returns to idle; entry contents are not cleared.
module keyed_expiry_timer_table_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ket_pkg::request_t  request,
  output logic               busy,
  output logic               done,
  output ket_pkg::result_t   result
);

  localparam int IdB  = ket_pkg::ID_BITS;
  localparam int TimB = ket_pkg::TIME_BITS;
  localparam int IdxW = ket_pkg::IDX_W;
  localparam int CntW = ket_pkg::CNT_W;

  // Entry storage, kept in descending order of remaining time
  logic [IdB-1:0]  key_mem [ket_pkg::CAPACITY];
  logic [TimB-1:0] rem_mem [ket_pkg::CAPACITY];

  ket_pkg::state_t  state, state_next;
  logic [CntW-1:0]  pos, pos_next;
  logic [CntW-1:0]  count, count_next;
  logic [CntW-1:0]  zcnt, zcnt_next;
  logic             shortened, shortened_next;
  logic [IdB-1:0]   req_id;
  logic [TimB-1:0]  req_time;
  ket_pkg::result_t res_next;
  logic             done_next;

  // Single write port
  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;
  logic [IdB-1:0]   wr_key;
  logic [TimB-1:0]  wr_rem;

  // Single read port
  logic [IdxW-1:0]  rd_idx;
  logic [IdB-1:0]   rd_key;
  logic [TimB-1:0]  rd_rem;

  logic [CntW-1:0]  pos_inc, pos_dec, count_dec;
  logic [TimB:0]    diff;
  logic             rem_gt;
  logic             accept;

  assign accept    = start && !busy;
  assign busy      = (state != ket_pkg::S_IDLE);
  assign pos_inc   = pos + 1'b1;
  assign pos_dec   = pos - 1'b1;
  assign count_dec = count - 1'b1;

  // Read address depends on which slot the current step looks at
  always_comb begin
    unique case (state)
      ket_pkg::S_REMOVE: rd_idx = pos_inc[IdxW-1:0];
      ket_pkg::S_PLACE:  rd_idx = pos_dec[IdxW-1:0];
      ket_pkg::S_POP:    rd_idx = count_dec[IdxW-1:0];
      default:           rd_idx = pos[IdxW-1:0];
    endcase
  end

  assign rd_key = key_mem[rd_idx];
  assign rd_rem = rem_mem[rd_idx];

  // Shared subtract/compare unit: entry time against request time
  assign diff   = {1'b0, rd_rem} - {1'b0, req_time};
  assign rem_gt = !diff[TimB] && (diff[TimB-1:0] != '0);

  // Sequencer
  always_comb begin
    state_next     = state;
    pos_next       = pos;
    count_next     = count;
    zcnt_next      = zcnt;
    shortened_next = shortened;
    wr_en          = 1'b0;
    wr_idx         = pos[IdxW-1:0];
    wr_key         = rd_key;
    wr_rem         = rd_rem;
    done_next      = 1'b0;
    res_next       = '0;
    res_next.last  = 1'b1;

    unique case (state)
      ket_pkg::S_IDLE: begin
        if (accept) begin
          pos_next       = '0;
          zcnt_next      = '0;
          shortened_next = 1'b0;
          state_next     = (request.action == ket_pkg::ACT_TICK) ?
                           ket_pkg::S_SUB : ket_pkg::S_SEARCH;
        end
      end

      // Look for the key, one slot per cycle
      ket_pkg::S_SEARCH: begin
        if (pos == count) begin
          if (count == CntW'(ket_pkg::CAPACITY)) begin
            res_next.status = ket_pkg::ST_DROPPED;
            done_next       = 1'b1;
            state_next      = ket_pkg::S_IDLE;
          end else begin
            state_next = ket_pkg::S_PLACE;
          end
        end else if (rd_key == req_id) begin
          if (rem_gt) begin
            shortened_next = 1'b1;
            state_next     = ket_pkg::S_REMOVE;
          end else begin
            res_next.status = ket_pkg::ST_UNCHANGED;
            done_next       = 1'b1;
            state_next      = ket_pkg::S_IDLE;
          end
        end else begin
          pos_next = pos_inc;
        end
      end

      // Close the gap left by the old entry
      ket_pkg::S_REMOVE: begin
        if (pos_inc < count) begin
          wr_en    = 1'b1;
          pos_next = pos_inc;
        end else begin
          count_next = count_dec;
          pos_next   = count_dec;
          state_next = ket_pkg::S_PLACE;
        end
      end

      // Walk from the back, shifting up entries not above the new time
      ket_pkg::S_PLACE: begin
        wr_en = 1'b1;
        if (pos != '0 && !rem_gt) begin
          pos_next = pos_dec;
        end else begin
          wr_key          = req_id;
          wr_rem          = req_time;
          count_next      = count + 1'b1;
          res_next.status = shortened ? ket_pkg::ST_SHORTENED : ket_pkg::ST_INSERTED;
          done_next       = 1'b1;
          state_next      = ket_pkg::S_IDLE;
        end
      end

      // Saturating subtract over all entries, counting zeros
      ket_pkg::S_SUB: begin
        if (pos == count) begin
          state_next = ket_pkg::S_POP;
        end else begin
          wr_en    = 1'b1;
          wr_rem   = rem_gt ? diff[TimB-1:0] : '0;
          pos_next = pos_inc;
          if (!rem_gt) begin
            zcnt_next = zcnt + 1'b1;
          end
        end
      end

      // Emit zero entries from the back
      ket_pkg::S_POP: begin
        done_next = 1'b1;
        if (zcnt == '0) begin
          res_next.status = ket_pkg::ST_NONE;
          state_next      = ket_pkg::S_IDLE;
        end else begin
          res_next.status              = ket_pkg::ST_EXPIRED;
          res_next.expired_id[IdB-1:0] = rd_key;
          res_next.last                = (zcnt == CntW'(1));
          count_next                   = count_dec;
          zcnt_next                    = zcnt - 1'b1;
          if (zcnt == CntW'(1)) begin
            state_next = ket_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_next = ket_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ket_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    pos       <= pos_next;
    zcnt      <= zcnt_next;
    shortened <= shortened_next;
    result    <= res_next;
    if (accept) begin
      req_id   <= request.object_id[IdB-1:0];
      req_time <= (request.action == ket_pkg::ACT_TICK) ?
                  request.elapsed[TimB-1:0] : request.lifetime[TimB-1:0];
    end
  end

  // Table write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx] <= wr_key;
      rem_mem[wr_idx] <= wr_rem;
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(ket_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request accepted but block not busy");

  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  a_expire_pops: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ket_pkg::ST_EXPIRED) |-> (count == $past(count) - 1'b1))
    else $error("expired result without a pop");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ket_pkg::ST_EXPIRED) |-> result.last)
    else $error("single result not marked last");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (done && result.last) |-> !busy)
    else $error("busy after last result");

endmodule
